### rtl/awma_pkg.sv
// Constants shared by the adaptive-window moving average block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package awma_pkg;

  // Number of history entries kept in the sample memory
  localparam int HISTORY_DEPTH = 32;

  localparam int TIME_W   = 19;                        // stored unsigned time, Q0.20 scale in 19 bits
  localparam int CFG_W    = 20;                        // window span register
  localparam int IN_W     = 24;                        // raw signed sample
  localparam int WUSED_W  = 6;                         // reported window port
  localparam int PTR_W    = $clog2(HISTORY_DEPTH);
  localparam int WIN_W    = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W    = TIME_W + $clog2(HISTORY_DEPTH);
  localparam int NUM_W    = CFG_W + 2;                 // 2*span + average
  localparam int DIV_W    = (SUM_W > NUM_W) ? SUM_W : NUM_W;
  localparam int DCNT_W   = $clog2(DIV_W);

  localparam logic [TIME_W-1:0] MAX_FRAME     = TIME_W'(419430);  // 0.4 s
  localparam logic [TIME_W-1:0] PAUSE_LIMIT   = TIME_W'(105);     // 0.0001 s
  localparam logic [TIME_W-1:0] THIRTIETH     = TIME_W'(34953);   // 1/30 s
  localparam logic [CFG_W-1:0]  WINDOW_RESET  = CFG_W'(262144);   // 0.25 s

endpackage

`default_nettype wire

### rtl/adaptive_window_moving_average.sv
// Adaptive-window moving average of frame times: top level.
// Sample memory, shared restoring divider and control; uses awma_pkg.
//
// Usage: each input item on in_valid/in_ready carries one signed Q0.20
// frame duration. It is clamped to 0..0.4 s and written into a circular
// sample memory of HISTORY_DEPTH entries. The window length comes from
// cfg_wdata (written with cfg_we while idle) divided by the previous
// average; the result carries the truncated mean of the newest window
// entries and the window length on out_valid/out_ready.
// After reset the block clears the sample memory to 1/30 s, one entry a
// cycle, over all HISTORY_DEPTH entries; in_ready stays low meanwhile.
// One item is worked on at a time, through the window division, the read
// and sum of the window from the single memory read port, the mean
// division and the posting of the result, then back to idle before the
// next item is taken. A pause sample skips the sum and the mean and is
// itself the result; when the previous average is zero the window
// division is skipped as well and the window is one. The next item is
// taken while a result waits in the output register; a stalled receiver
// holds only the final step.
`timescale 1ns / 1ps
`default_nettype none

module adaptive_window_moving_average
  import awma_pkg::*;
(
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire signed [IN_W-1:0]    in_frame_time,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic [TIME_W-1:0]        out_average_time,
  output logic [WUSED_W-1:0]       out_window_used,
  input  wire                      cfg_we,
  input  wire [CFG_W-1:0]          cfg_wdata
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIVW,
    ST_SUM,
    ST_DIVA,
    ST_FINISH
  } state_t;

  state_t              state_r;
  logic [CFG_W-1:0]    window_r;
  logic [TIME_W-1:0]   prev_avg_r;
  logic [TIME_W-1:0]   sample_r;
  logic [TIME_W-1:0]   avg_r;
  logic [WIN_W-1:0]    win_r;
  logic [PTR_W-1:0]    wr_ptr_r;
  logic [PTR_W-1:0]    rd_ptr_r;
  logic [PTR_W-1:0]    clr_ptr_r;
  logic [WIN_W-1:0]    issue_cnt_r;
  logic                rd_pend_r;
  logic [SUM_W-1:0]    sum_r;
  logic [DIV_W-1:0]    div_rem_r;
  logic [DIV_W-1:0]    div_quo_r;
  logic [DIV_W-1:0]    div_den_r;
  logic [DCNT_W-1:0]   div_cnt_r;
  logic                out_valid_r;
  logic [TIME_W-1:0]   out_avg_r;
  logic [WIN_W-1:0]    out_win_r;

  // sample memory
  logic [TIME_W-1:0]   mem [HISTORY_DEPTH];
  logic [TIME_W-1:0]   rd_data_r;
  logic                mem_we;
  logic [PTR_W-1:0]    mem_waddr;
  logic [TIME_W-1:0]   mem_wdata;
  logic                mem_re;

  logic                accept;
  logic [TIME_W-1:0]   sample_clamped;
  logic [PTR_W-1:0]    wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_nxt;
  logic [DIV_W:0]      rem_shift;
  logic                div_ge;
  logic [DIV_W-1:0]    div_rem_nxt;
  logic [DIV_W-1:0]    div_quo_nxt;
  logic [WIN_W-1:0]    win_nxt;

  assign in_ready         = (state_r == ST_IDLE);
  assign accept           = in_valid && in_ready;
  assign out_valid        = out_valid_r;
  assign out_average_time = out_avg_r;
  assign out_window_used  = WUSED_W'(out_win_r);

  always_comb begin
    if (in_frame_time[IN_W-1]) begin
      sample_clamped = '0;
    end else if (in_frame_time > $signed({{(IN_W-TIME_W){1'b0}}, MAX_FRAME})) begin
      sample_clamped = MAX_FRAME;
    end else begin
      sample_clamped = in_frame_time[TIME_W-1:0];
    end
  end

  // circular pointers, wrap at any depth
  assign wr_ptr_nxt = (wr_ptr_r == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == '0) ? PTR_W'(HISTORY_DEPTH - 1) : rd_ptr_r - 1'b1;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_ptr_nxt;
    mem_wdata = sample_clamped;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_ptr_r;
      mem_wdata = THIRTIETH;
    end else if (accept) begin
      mem_we    = 1'b1;
    end
  end

  assign mem_re = (state_r == ST_SUM) && (issue_cnt_r != win_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  // one restoring division step
  assign rem_shift   = {div_rem_r, div_quo_r[DIV_W-1]};
  assign div_ge      = rem_shift >= {1'b0, div_den_r};
  assign div_rem_nxt = div_ge ? DIV_W'(rem_shift - {1'b0, div_den_r}) : DIV_W'(rem_shift);
  assign div_quo_nxt = {div_quo_r[DIV_W-2:0], div_ge};

  // saturate the rounded window to 1..depth
  always_comb begin
    if (div_quo_nxt > DIV_W'(HISTORY_DEPTH)) begin
      win_nxt = WIN_W'(HISTORY_DEPTH);
    end else if (div_quo_nxt == '0) begin
      win_nxt = WIN_W'(1);
    end else begin
      win_nxt = WIN_W'(div_quo_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      window_r    <= WINDOW_RESET;
      prev_avg_r  <= THIRTIETH;
      wr_ptr_r    <= '0;
      clr_ptr_r   <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_r <= cfg_wdata;
      end
      // drop the taken result unless a new one is posted in the same cycle
      if (out_valid_r && out_ready && (state_r != ST_FINISH)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_CLEAR: begin
          clr_ptr_r <= clr_ptr_r + 1'b1;
          if (clr_ptr_r == PTR_W'(HISTORY_DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (accept) begin
            sample_r  <= sample_clamped;
            wr_ptr_r  <= wr_ptr_nxt;
            div_rem_r <= '0;
            div_quo_r <= DIV_W'({window_r, 1'b0}) + DIV_W'(prev_avg_r);
            div_den_r <= DIV_W'({prev_avg_r, 1'b0});
            div_cnt_r <= DCNT_W'(DIV_W - 1);
            if (prev_avg_r == '0) begin
              win_r <= WIN_W'(1);
              if (sample_clamped < PAUSE_LIMIT) begin
                avg_r   <= sample_clamped;
                state_r <= ST_FINISH;
              end else begin
                state_r <= ST_SUM;
              end
            end else begin
              state_r <= ST_DIVW;
            end
            rd_ptr_r    <= wr_ptr_nxt;
            issue_cnt_r <= '0;
            sum_r       <= '0;
            rd_pend_r   <= 1'b0;
          end
        end

        ST_DIVW: begin
          div_rem_r <= div_rem_nxt;
          div_quo_r <= div_quo_nxt;
          div_cnt_r <= div_cnt_r - 1'b1;
          if (div_cnt_r == '0) begin
            win_r <= win_nxt;
            if (sample_r < PAUSE_LIMIT) begin
              avg_r   <= sample_r;
              state_r <= ST_FINISH;
            end else begin
              state_r <= ST_SUM;
            end
          end
        end

        ST_SUM: begin
          if (rd_pend_r) begin
            sum_r <= sum_r + SUM_W'(rd_data_r);
          end
          if (issue_cnt_r != win_r) begin
            issue_cnt_r <= issue_cnt_r + 1'b1;
            rd_ptr_r    <= rd_ptr_nxt;
            rd_pend_r   <= 1'b1;
          end else begin
            rd_pend_r <= 1'b0;
            if (!rd_pend_r) begin
              div_rem_r <= '0;
              div_quo_r <= DIV_W'(sum_r);
              div_den_r <= DIV_W'(win_r);
              div_cnt_r <= DCNT_W'(DIV_W - 1);
              state_r   <= ST_DIVA;
            end
          end
        end

        ST_DIVA: begin
          div_rem_r <= div_rem_nxt;
          div_quo_r <= div_quo_nxt;
          div_cnt_r <= div_cnt_r - 1'b1;
          if (div_cnt_r == '0) begin
            avg_r   <= TIME_W'(div_quo_nxt);
            state_r <= ST_FINISH;
          end
        end

        ST_FINISH: begin
          // hold until the output register is free
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_avg_r   <= avg_r;
            out_win_r   <= win_r;
            prev_avg_r  <= avg_r;
            state_r     <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### verif/adaptive_window_moving_average_tb.sv
// Self-checking testbench for adaptive_window_moving_average.
// Predicts every smoothed frame time in a local model of the block and checks the
// results in order; depends on awma_pkg and the block's top level only.
`timescale 1ns / 1ps

module adaptive_window_moving_average_tb;
  import awma_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 120;   // longer than one worst-case item
  localparam int LONG_HOLD = 1500;      // receiver hold-off in the back-pressure phase

  typedef struct packed {
    logic [TIME_W-1:0]  avg;
    logic [WUSED_W-1:0] win;
  } smooth_t;

  typedef struct {
    logic signed [IN_W-1:0] frame;
    bit                     drain;   // hold until every result is back
  } frame_item_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [IN_W-1:0]  in_frame_time = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [TIME_W-1:0]       out_average_time;
  logic [WUSED_W-1:0]      out_window_used;
  logic                    cfg_we = 1'b0;
  logic [CFG_W-1:0]        cfg_wdata = '0;

  frame_item_t       frame_q[$];
  smooth_t           avg_q[$];
  logic              drained = 1'b1;
  int                send_idle_pct = 0;
  int                stall_pct = 0;
  bit                hold_phase = 1'b0;
  int                mismatches = 0;
  int unsigned       cycle_count = 0;

  // Model state
  logic [CFG_W-1:0]  span_model = WINDOW_RESET;
  logic [TIME_W-1:0] hist [HISTORY_DEPTH];
  logic [TIME_W-1:0] prev_avg;

  adaptive_window_moving_average dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_frame_time    (in_frame_time),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_average_time (out_average_time),
    .out_window_used  (out_window_used),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Clamp, shift into the history, size the window from the last average and take the mean.
  function automatic smooth_t next_average(input logic signed [IN_W-1:0] raw);
    logic [TIME_W-1:0] sample;
    logic [63:0]       win;
    logic [63:0]       sum;
    logic [63:0]       p;
    smooth_t           r;
    if (raw < 0) begin
      sample = '0;
    end else if (raw > IN_W'(MAX_FRAME)) begin
      sample = MAX_FRAME;
    end else begin
      sample = raw[TIME_W-1:0];
    end
    for (int i = HISTORY_DEPTH - 1; i > 0; i--) hist[i] = hist[i-1];
    hist[0] = sample;
    if (prev_avg == '0) begin
      win = 1;
    end else begin
      p = 64'(prev_avg);
      win = (64'(span_model) * 2 + p) / (p * 2);
      if (win > HISTORY_DEPTH) win = HISTORY_DEPTH;
      if (win < 1) win = 1;
    end
    sum = 0;
    for (int i = 0; i < win; i++) sum += 64'(hist[i]);
    r.avg = TIME_W'(sum / win);
    if (sample < PAUSE_LIMIT) r.avg = sample;   // pause: pass the sample through
    r.win = WUSED_W'(win);
    prev_avg = r.avg;
    return r;
  endfunction

  task automatic flag_error(input string msg);
    if (mismatches < 10) $display("[%0t] ERROR: %s", $realtime, msg);
    mismatches++;
  endtask

  // Driver: one nonblocking update of in_valid per edge.
  always @(posedge clk) begin : driver
    logic next_valid;
    frame_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid && !in_ready;
      if ((!in_valid || in_ready) && frame_q.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        // a drain item waits for an empty pipeline, as registered by the monitor
        if (!frame_q[0].drain || (!in_valid && drained)) begin
          it = frame_q.pop_front();
          in_frame_time <= it.frame;
          next_valid = 1'b1;
        end
      end
      in_valid <= next_valid;
    end
  end

  // Receiver: random stalls, plus one long hold-off while the sender keeps going.
  always @(posedge clk) begin : receiver
    int  hold_count;
    bit  hold_done;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_count = 0;
      hold_done = 1'b0;
    end else if (hold_phase && !hold_done) begin
      out_ready <= 1'b0;
      hold_count++;
      if (hold_count >= LONG_HOLD) hold_done = 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: check results first, then predict the item taken at this edge.
  always @(posedge clk) begin : monitor
    smooth_t got;
    smooth_t want;
    if (!rst_n) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) hist[i] = THIRTIETH;
      prev_avg = THIRTIETH;
      avg_q.delete();
      drained <= 1'b1;
    end else begin
      if (out_valid && out_ready) begin
        got.avg = out_average_time;
        got.win = out_window_used;
        if (avg_q.size() == 0) begin
          flag_error($sformatf("unexpected result avg=%0d win=%0d", got.avg, got.win));
        end else begin
          want = avg_q.pop_front();
          if (got.avg !== want.avg || got.win !== want.win)
            flag_error($sformatf("avg exp=%0d got=%0d, win exp=%0d got=%0d",
                                 want.avg, got.avg, want.win, got.win));
        end
      end
      if (in_valid && in_ready) avg_q.push_back(next_average(in_frame_time));
      drained <= (avg_q.size() == 0);
    end
  end

  task automatic queue_item(input logic signed [IN_W-1:0] f, input bit drain = 1'b0);
    frame_item_t it;
    it.frame = f;
    it.drain = drain;
    frame_q.push_back(it);
  endtask

  function automatic logic signed [IN_W-1:0] rand_frame();
    case ($urandom_range(9))
      0:       return IN_W'($urandom());
      1:       return IN_W'($urandom_range(0, 110));        // around the pause limit
      2:       return -IN_W'($urandom_range(1, 8388608));
      3:       return IN_W'($urandom_range(400000, 8388607));
      default: return IN_W'($urandom_range(4000, 90000));   // ordinary frame times
    endcase
  endfunction

  task automatic random_items(input int n, input int drain_pct);
    for (int i = 0; i < n; i++) queue_item(rand_frame(), $urandom_range(99) < drain_pct);
  endtask

  task automatic wait_idle();
    while (frame_q.size() != 0 || in_valid || avg_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] v);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    span_model = v;
    @(negedge clk);
  endtask

  initial begin : timeout
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("adaptive_window_moving_average regression: fail");
    $finish;
  end

  initial begin : sequencer
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: field extremes, clamps, pause limit edges, zero average, default span
    queue_item(24'sd34953);
    queue_item(24'sd0);
    queue_item(24'sd100000);
    queue_item(-24'sd1);
    queue_item(24'sd50000);
    queue_item(-24'sd8388608);
    queue_item(24'sd8388607);
    queue_item(24'sd419430);
    queue_item(24'sd419431);
    queue_item(24'sd524287);
    queue_item(24'sd104);
    queue_item(24'sd105);
    queue_item(24'sd106);
    queue_item(24'sd1);
    queue_item(24'sd16667);
    queue_item(24'sd8333);
    queue_item(24'sd200000);
    queue_item(24'sd419429);
    queue_item(-24'sd419430);
    queue_item(24'sd33333);
    queue_item(24'sd2);
    queue_item(24'sd70000);

    write_window(CFG_W'(1048575));
    random_items(250, 0);

    write_window(CFG_W'(1));
    send_idle_pct = 51;
    random_items(250, 0);

    write_window(CFG_W'(0));   // zero span: window saturates to one
    send_idle_pct = 0;
    stall_pct = 51;
    random_items(120, 0);

    write_window(CFG_W'($urandom_range(1, 1048575)));
    send_idle_pct = 34;
    stall_pct = 34;
    random_items(250, 0);

    // Back-pressure: long receiver hold-off with the sender running flat out
    write_window(CFG_W'(174765));
    send_idle_pct = 0;
    stall_pct = 0;
    hold_phase = 1'b1;
    random_items(40, 0);
    queue_item(rand_frame(), 1'b1);
    random_items(40, 0);
    wait_idle();
    hold_phase = 1'b0;

    write_window(WINDOW_RESET);
    send_idle_pct = 34;
    stall_pct = 34;
    random_items(250, 3);

    wait_idle();
    if (mismatches == 0) begin
      $display("adaptive_window_moving_average regression: pass");
    end else begin
      $display("adaptive_window_moving_average regression: fail");
    end
    $finish;
  end

endmodule
